// ===== src/fos_pkg.sv =====
// fos_pkg: shared types, codes and the charge table of the fiber overlap stitcher
// no dependencies
`default_nettype none
package fos_pkg;

    localparam int SAMPLE_W    = 11;   // ok, adc, cap id
    localparam int CHARGE_W    = 26;
    localparam int RES_LIMIT   = 64;
    localparam int NW          = 7;    // holds RES_LIMIT
    localparam int NO_OVL_SPAN = 4;    // capid-only match at count-4 means no overlap

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_EOE    = 1'b1;

    localparam logic [1:0] CFG_NUM_FIBERS   = 2'd0;
    localparam logic [1:0] CFG_WINDOW_START = 2'd1;
    localparam logic [1:0] CFG_WINDOW_END   = 2'd2;

    typedef struct packed {
        logic       func;
        logic [1:0] fiber;
        logic       sample_ok;
        logic [7:0] sample_adc;
        logic [1:0] cap_id;
    } t_in;

    typedef struct packed {
        logic [7:0]          result_adc;
        logic [CHARGE_W-1:0] charge;
        logic                valid_res;
        logic                last;
    } t_out;

    localparam logic [CHARGE_W-1:0] CHARGE_ROM [256] = '{
        158,473,788,1100,1420,1730,2050,2360,
        2680,2990,3310,3620,3940,4250,4570,4880,
        5360,6010,6660,7300,7950,8600,9250,9890,
        10500,11200,11800,12500,13100,13800,14400,15100,
        15700,16400,17000,17700,18600,19900,21200,22500,
        23800,25100,26400,27700,28900,30200,31500,32800,
        34100,35400,36700,38000,39300,40600,41800,43100,
        44400,46400,49000,51600,54200,56800,59400,62000,
        56900,59400,61900,64500,67000,69500,72000,74500,
        77100,79600,82100,84600,87100,89700,92200,94700,
        96000,101000,106000,112000,117000,122000,127000,132000,
        137000,143000,148000,153000,158000,163000,169000,174000,
        179000,184000,189000,194000,202000,212000,223000,233000,
        243000,254000,264000,274000,285000,295000,305000,315000,
        326000,336000,346000,357000,367000,377000,388000,398000,
        408000,424000,445000,465000,486000,507000,528000,549000,
        508000,528000,548000,568000,588000,608000,628000,648000,
        668000,689000,709000,729000,749000,769000,789000,809000,
        840000,881000,922000,963000,1000000,1040000,1090000,1130000,
        1170000,1210000,1250000,1290000,1330000,1370000,1410000,1450000,
        1500000,1540000,1580000,1620000,1680000,1760000,1840000,1930000,
        2010000,2090000,2170000,2250000,2340000,2420000,2500000,2580000,
        2660000,2750000,2830000,2910000,2990000,3070000,3160000,3240000,
        3320000,3440000,3610000,3770000,3940000,4100000,4270000,4430000,
        4110000,4270000,4430000,4590000,4760000,4920000,5080000,5250000,
        5410000,5570000,5740000,5900000,6060000,6220000,6390000,6550000,
        6800000,7130000,7470000,7800000,8140000,8470000,8800000,9140000,
        9470000,9810000,10100000,10500000,10800000,11100000,11500000,11800000,
        12100000,12500000,12800000,13100000,13700000,14500000,15200000,16000000,
        16800000,17600000,18300000,19100000,19900000,20600000,21400000,22200000,
        23000000,23700000,24500000,25300000,26100000,26800000,27600000,28400000,
        29100000,30200000,31600000,32900000,34300000,35600000,37000000,38400000
    };

    function automatic logic [CHARGE_W-1:0] charge_of(input logic [7:0] adc);
        return CHARGE_ROM[adc];
    endfunction

endpackage
`default_nettype wire

// ===== src/fos_mem.sv =====
// fos_mem: sample store, one write port and two registered read ports
// depends on fos_pkg for the sample width
`default_nettype none
module fos_mem
    import fos_pkg::*;
#(
    parameter int AW = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [AW-1:0]       i_waddr,
    input  wire logic [SAMPLE_W-1:0] i_wdata,
    input  wire logic                i_re_a,
    input  wire logic [AW-1:0]       i_raddr_a,
    output logic      [SAMPLE_W-1:0] o_rdata_a,
    input  wire logic                i_re_b,
    input  wire logic [AW-1:0]       i_raddr_b,
    output logic      [SAMPLE_W-1:0] o_rdata_b
);
    logic [SAMPLE_W-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end
endmodule
`default_nettype wire

// ===== src/fiber_overlap_stitcher_core.sv =====
// fiber_overlap_stitcher_core: top level, sample loading, overlap search sequencer, output
// depends on fos_pkg and fos_mem
`default_nettype none
// Sample items (func 0) are taken one per cycle while idle. An end-of-event item holds
// the input stalled while a small sequencer walks the sample store. For each adjacent
// fiber pair the overlap search tries cut lengths in turn; for each compared sample pair
// it does one store read and then one compare. Stitching then reads each walked sample
// and decides whether to keep it, waiting while the output is stalled, and a closing
// state sends the last result.
module fiber_overlap_stitcher_core
    import fos_pkg::*;
#(
    parameter int MAX_FIBERS  = 4,
    parameter int MAX_SAMPLES = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_addr,
    input  wire logic [5:0] i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in        i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out            o_out_data
);
    localparam int FW  = (MAX_FIBERS > 1) ? $clog2(MAX_FIBERS) : 1;
    localparam int FCW = $clog2(MAX_FIBERS + 1);
    localparam int SW  = $clog2(MAX_SAMPLES);
    localparam int CW  = $clog2(MAX_SAMPLES + 2);
    localparam int BW  = $clog2(MAX_FIBERS * MAX_SAMPLES + 1);
    localparam int AW  = FW + SW;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CUT_F  = 8'b0000_0010,
        S_CUT_NC = 8'b0000_0100,
        S_RD     = 8'b0000_1000,
        S_CMP    = 8'b0001_0000,
        S_EM_A   = 8'b0010_0000,
        S_EM_D   = 8'b0100_0000,
        S_FLUSH  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_num;
    logic [5:0] r_ws, r_we;
    logic [CW-1:0] r_cnt [MAX_FIBERS];
    logic [CW-1:0] n_cnt [MAX_FIBERS];
    logic [CW-1:0] r_cut [MAX_FIBERS];
    logic [CW-1:0] n_cut [MAX_FIBERS];
    logic [CW-1:0] r_long, n_long;
    logic [FCW-1:0] r_f, n_f;
    logic [CW-1:0] r_nts, n_nts, r_ncheck, n_ncheck, r_k, n_k, r_lat, n_lat, r_i, n_i;
    logic r_lat_v, n_lat_v, r_cap, n_cap, r_adc, n_adc, r_va, n_va, r_vb, n_vb;
    logic r_keep, n_keep, r_pend_v, n_pend_v;
    logic [7:0] r_pend, n_pend;
    logic [BW-1:0] r_comb, n_comb;
    logic [NW-1:0] r_n, n_n;
    logic r_out_valid;
    t_out r_out;

    logic out_free, out_load;
    t_out out_data;
    logic mem_we, rd_a_en, rd_b_en;
    logic [AW-1:0] mem_waddr, rd_a_addr, rd_b_addr;
    logic [SAMPLE_W-1:0] mem_wdata, rd_a_data, rd_b_data;

    logic [FCW-1:0] nf;
    logic [FW-1:0] fi, fib, in_fi;
    logic [FCW+1:0] fiber_ext;
    logic [CW-1:0] eff, ia, final_cut, in_cnt1;
    logic pa_ok, pb_ok, both, cap_n, adc_n, win_ok, hit;

    fos_mem #(.AW(AW)) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re_a    (rd_a_en),
        .i_raddr_a (rd_a_addr),
        .o_rdata_a (rd_a_data),
        .i_re_b    (rd_b_en),
        .i_raddr_b (rd_b_addr),
        .o_rdata_b (rd_b_data)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        nf        = (32'(r_num) > MAX_FIBERS) ? FCW'(MAX_FIBERS) : FCW'(r_num);
        fi        = r_f[FW-1:0];
        fib       = FW'(r_f + 1'b1);
        fiber_ext = {{FCW{1'b0}}, i_in_data.fiber};
        in_fi     = fiber_ext[FW-1:0];
        in_cnt1   = r_cnt[in_fi] + 1'b1;
        eff       = (r_cnt[fi] == '0) ? r_long : r_cnt[fi];
        ia        = r_nts - r_ncheck + r_k;
        final_cut = !r_lat_v ? r_nts
                  : ((32'(r_nts) >= NO_OVL_SPAN) && (r_lat == r_nts - CW'(NO_OVL_SPAN))) ? r_nts
                  : r_lat;
        pa_ok     = r_va && rd_a_data[10];
        pb_ok     = r_vb && rd_b_data[10];
        both      = pa_ok && pb_ok;
        cap_n     = both && r_cap && (rd_a_data[1:0] == rd_b_data[1:0]);
        adc_n     = both && r_adc && (rd_a_data[9:2] == rd_b_data[9:2]);
        win_ok    = (32'(r_comb) >= 32'(r_ws)) && ((r_we == '0) || (32'(r_comb) <= 32'(r_we)));
        hit       = r_keep && rd_a_data[10] && (32'(r_n) < RES_LIMIT);
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_cut    = r_cut;
        n_long   = r_long;
        n_f      = r_f;
        n_nts    = r_nts;
        n_ncheck = r_ncheck;
        n_k      = r_k;
        n_lat    = r_lat;
        n_lat_v  = r_lat_v;
        n_cap    = r_cap;
        n_adc    = r_adc;
        n_va     = r_va;
        n_vb     = r_vb;
        n_i      = r_i;
        n_keep   = r_keep;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_comb   = r_comb;
        n_n      = r_n;
        mem_we    = 1'b0;
        mem_waddr = {in_fi, r_cnt[in_fi][SW-1:0]};
        mem_wdata = {i_in_data.sample_ok, i_in_data.sample_adc, i_in_data.cap_id};
        rd_a_en   = 1'b0;
        rd_a_addr = {fi, ia[SW-1:0]};
        rd_b_en   = 1'b0;
        rd_b_addr = {fib, r_k[SW-1:0]};
        out_load  = 1'b0;
        out_data  = '{result_adc: r_pend, charge: charge_of(r_pend),
                      valid_res: 1'b1, last: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.func == FUNC_EOE) begin
                        n_f     = '0;
                        n_state = S_CUT_F;
                    end else if ((fiber_ext < (FCW+2)'(nf)) &&
                                 (32'(r_cnt[in_fi]) < MAX_SAMPLES)) begin
                        mem_we       = 1'b1;
                        n_cnt[in_fi] = in_cnt1;
                        if (in_cnt1 > r_long) begin
                            n_long = in_cnt1;
                        end
                    end
                end
            end
            S_CUT_F: begin
                if (r_f >= nf) begin
                    n_f     = '0;
                    n_i     = '0;
                    n_comb  = '0;
                    n_n     = '0;
                    n_state = S_EM_A;
                end else if (r_f + 1'b1 >= nf) begin
                    // last fiber keeps its own count
                    n_cut[fi] = eff;
                    n_f       = r_f + 1'b1;
                end else begin
                    n_nts    = eff;
                    n_ncheck = CW'(1);
                    n_lat_v  = 1'b0;
                    n_state  = S_CUT_NC;
                end
            end
            S_CUT_NC: begin
                if (r_ncheck > r_nts) begin
                    n_cut[fi] = final_cut;
                    n_f       = r_f + 1'b1;
                    n_state   = S_CUT_F;
                end else begin
                    n_k     = '0;
                    n_cap   = 1'b1;
                    n_adc   = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                // tail of fiber f against head of fiber f+1
                rd_a_en = 1'b1;
                rd_b_en = 1'b1;
                n_va    = ia < r_cnt[fi];
                n_vb    = r_k < r_cnt[fib];
                n_state = S_CMP;
            end
            S_CMP: begin
                if (both && (r_k + 1'b1 < r_ncheck)) begin
                    n_cap   = cap_n;
                    n_adc   = adc_n;
                    n_k     = r_k + 1'b1;
                    n_state = S_RD;
                end else begin
                    if (cap_n && !r_lat_v) begin
                        n_lat   = r_nts - r_ncheck;
                        n_lat_v = 1'b1;
                    end
                    if (cap_n && adc_n) begin
                        n_cut[fi] = r_nts - r_ncheck;
                        n_f       = r_f + 1'b1;
                        n_state   = S_CUT_F;
                    end else begin
                        n_ncheck = r_ncheck + 1'b1;
                        n_state  = S_CUT_NC;
                    end
                end
            end
            S_EM_A: begin
                if (r_f >= nf) begin
                    n_state = S_FLUSH;
                end else if (r_i >= r_cut[fi]) begin
                    n_f = r_f + 1'b1;
                    n_i = '0;
                end else begin
                    rd_a_en   = 1'b1;
                    rd_a_addr = {fi, r_i[SW-1:0]};
                    n_keep    = win_ok && (r_i < r_cnt[fi]);
                    n_comb    = r_comb + 1'b1;
                    n_i       = r_i + 1'b1;
                    n_state   = S_EM_D;
                end
            end
            S_EM_D: begin
                // one result is held back so the final one can carry last
                if (!hit) begin
                    n_state = S_EM_A;
                end else if (!r_pend_v) begin
                    n_pend   = rd_a_data[9:2];
                    n_pend_v = 1'b1;
                    n_n      = r_n + 1'b1;
                    n_state  = S_EM_A;
                end else if (out_free) begin
                    out_load = 1'b1;
                    n_pend   = rd_a_data[9:2];
                    n_n      = r_n + 1'b1;
                    n_state  = S_EM_A;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_pend_v) begin
                        out_data.last = 1'b1;
                    end else begin
                        out_data = '{result_adc: 8'd0, charge: '0,
                                     valid_res: 1'b0, last: 1'b1};
                    end
                    n_pend_v = 1'b0;
                    for (int j = 0; j < MAX_FIBERS; j++) begin
                        n_cnt[j] = '0;
                    end
                    n_long  = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num       <= 3'd4;
            r_ws        <= '0;
            r_we        <= '0;
            r_long      <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < MAX_FIBERS; j++) begin
                r_cnt[j] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_long   <= n_long;
            r_pend_v <= n_pend_v;
            r_cnt    <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_NUM_FIBERS:   r_num <= i_cfg_wdata[2:0];
                    CFG_WINDOW_START: r_ws  <= i_cfg_wdata;
                    CFG_WINDOW_END:   r_we  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cut    <= n_cut;
        r_f      <= n_f;
        r_nts    <= n_nts;
        r_ncheck <= n_ncheck;
        r_k      <= n_k;
        r_lat    <= n_lat;
        r_lat_v  <= n_lat_v;
        r_cap    <= n_cap;
        r_adc    <= n_adc;
        r_va     <= n_va;
        r_vb     <= n_vb;
        r_i      <= n_i;
        r_keep   <= n_keep;
        r_pend   <= n_pend;
        r_comb   <= n_comb;
        r_n      <= n_n;
        if (out_load) begin
            r_out <= out_data;
        end
    end

    a_held_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("held result left over in idle");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && out_free) |=> (r_out_valid && r_out.last))
        else $error("event closed without a last transfer");

    a_cmp_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_k < r_ncheck && r_ncheck <= r_nts))
        else $error("compare index out of range");

    a_res_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM_A || r_state == S_EM_D) |-> (32'(r_n) <= RES_LIMIT))
        else $error("result count past limit");

endmodule
`default_nettype wire
